FILE: src/orb_pkg.sv
// Shared types and constants for the overwriting ring buffer.
// No dependencies; imported by the front end, the back end, the top level and the testbench.
`timescale 1ns / 1ps

package orb_pkg;

  localparam int SIZE_W    = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_LVL_W = 3;
  localparam int JOB_DEPTH = 2;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } orb_cmd_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_in;
  } orb_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last;
  } orb_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] count;
    logic [SIZE_W-1:0] size;
  } orb_job_t;

endpackage

FILE: src/overwriting_ring_buffer.sv
// Overwriting byte ring buffer: pushes are accepted back to back while full is low.
// A drain word becomes a job; its bytes are read from the store and leave on the result ports
// through the result queue, one byte per cycle while pop is held, paced by the store read port.
// Input shows full from a drain of a non-empty buffer until its last byte is read from the store.
// Synchronous reset: buffer empty, active size 8; store contents not cleared.
`timescale 1ns / 1ps

module overwriting_ring_buffer
  import orb_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  orb_in_t           in_data,
  output logic              empty,
  input  logic              pop,
  output orb_out_t          out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);

  logic                 accept;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;
  logic                 job_push;
  orb_job_t             job_in;
  orb_job_t             job_out;
  logic                 job_empty;
  logic                 job_pop;
  logic                 back_busy;
  logic [OUT_LVL_W-1:0] out_level;
  logic                 out_push;
  orb_out_t             out_word;

  assign full   = !job_empty || back_busy;
  assign accept = push && !full;

  orb_front #(.DEPTH(DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_data   (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job       (job_in)
  );

  orb_fifo #(.WIDTH($bits(orb_job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (job_push),
    .wdata (job_in),
    .rd_en (job_pop),
    .rdata (job_out),
    .empty (job_empty),
    .full  (),
    .level ()
  );

  orb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  orb_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_level (out_level),
    .out_push  (out_push),
    .out_word  (out_word)
  );

  orb_fifo #(.WIDTH($bits(orb_out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (out_push),
    .wdata (out_word),
    .rd_en (pop),
    .rdata (out_data),
    .empty (empty),
    .full  (),
    .level (out_level)
  );

endmodule

FILE: src/orb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module orb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/orb_fifo.sv
// Small register FIFO with fill level, used for the drain job queue and the result queue.
// No dependencies.
`timescale 1ns / 1ps

module orb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [LW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign empty = (count == '0);
  assign full  = (count == LW'(DEPTH));
  assign level = count;
  assign rdata = mem[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/orb_front.sv
// Front end: holds the size register and the write pointer and fill count,
// writes pushed bytes to the store and turns drains into jobs. Uses orb_pkg.
`timescale 1ns / 1ps

module orb_front
  import orb_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_data,
  input  logic                     accept,
  input  orb_in_t                  in_data,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [7:0]               ram_wdata,
  output logic                     job_push,
  output orb_job_t                 job
);

  localparam int AW = $clog2(DEPTH);

  logic [SIZE_W-1:0] active_size;
  logic [SIZE_W-1:0] write_pos;
  logic [SIZE_W-1:0] write_pos_next;
  logic [SIZE_W-1:0] fill_count;
  logic [SIZE_W-1:0] fill_count_next;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W:0]   start_sum;
  logic [SIZE_W:0]   start_wrap;
  logic              is_push;
  logic              is_drain;

  always_comb begin
    if (active_size == '0) begin
      size = SIZE_W'(1);
    end else if (int'(active_size) > DEPTH) begin
      size = SIZE_W'(DEPTH);
    end else begin
      size = active_size;
    end
  end

  assign is_push  = accept && (orb_cmd_t'(in_data.command) == CMD_PUSH);
  assign is_drain = accept && (orb_cmd_t'(in_data.command) == CMD_DRAIN);

  assign ram_we    = is_push;
  assign ram_waddr = AW'(write_pos);
  assign ram_wdata = in_data.data_in;

  // oldest entry: (write_pos - fill_count) wrapped at size
  assign start_sum  = {1'b0, write_pos} + {1'b0, size} - {1'b0, fill_count};
  assign start_wrap = (start_sum >= {1'b0, size}) ? start_sum - {1'b0, size} : start_sum;

  assign job_push  = is_drain && (fill_count != '0);
  assign job.start = start_wrap[SIZE_W-1:0];
  assign job.count = fill_count;
  assign job.size  = size;

  always_comb begin
    write_pos_next  = write_pos;
    fill_count_next = fill_count;
    if (is_push) begin
      write_pos_next  = (write_pos + 1'b1 >= size) ? '0 : write_pos + 1'b1;
      fill_count_next = (fill_count < size) ? fill_count + 1'b1 : fill_count;
    end else if (is_drain) begin
      fill_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= SIZE_W'(8);
      write_pos   <= '0;
      fill_count  <= '0;
    end else if (cfg_we) begin
      active_size <= cfg_data;
      write_pos   <= '0;
      fill_count  <= '0;
    end else begin
      write_pos  <= write_pos_next;
      fill_count <= fill_count_next;
    end
  end

endmodule

FILE: src/orb_back.sv
// Back end: takes drain jobs, reads the store oldest first and feeds the
// result queue, throttled by its free space. Uses orb_pkg.
`timescale 1ns / 1ps

module orb_back
  import orb_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     job_valid,
  input  orb_job_t                 job,
  output logic                     job_pop,
  output logic                     busy,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [7:0]               ram_rdata,
  input  logic [OUT_LVL_W-1:0]     out_level,
  output logic                     out_push,
  output orb_out_t                 out_word
);

  localparam int AW = $clog2(DEPTH);

  logic [SIZE_W-1:0] pos;
  logic [SIZE_W-1:0] pos_next;
  logic [SIZE_W-1:0] remain;
  logic [SIZE_W-1:0] remain_next;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] size_next;
  logic              busy_next;
  logic              rd_valid;
  logic              rd_last;
  logic              credit;
  logic              issue;

  assign credit    = (out_level + OUT_LVL_W'(rd_valid)) < OUT_LVL_W'(OUT_DEPTH);
  assign issue     = busy && credit;
  assign job_pop   = !busy && job_valid;
  assign ram_re    = issue;
  assign ram_raddr = AW'(pos);

  assign out_push          = rd_valid;
  assign out_word.data_out = ram_rdata;
  assign out_word.last     = rd_last;

  always_comb begin
    busy_next   = busy;
    pos_next    = pos;
    remain_next = remain;
    size_next   = size;
    if (job_pop) begin
      busy_next   = 1'b1;
      pos_next    = job.start;
      remain_next = job.count;
      size_next   = job.size;
    end else if (issue) begin
      pos_next    = (pos + 1'b1 >= size) ? '0 : pos + 1'b1;
      remain_next = remain - 1'b1;
      busy_next   = (remain != SIZE_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    remain <= remain_next;
    size   <= size_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      busy     <= busy_next;
      rd_valid <= issue;
      rd_last  <= issue && (remain == SIZE_W'(1));
    end
  end

endmodule

FILE: verif/tb_overwriting_ring_buffer.sv
// Self-checking testbench for overwriting_ring_buffer: push/drain words, size changes.
// Predicts drained bytes from its own ring model and checks each popped word in order.
// Depends on orb_pkg and overwriting_ring_buffer; needs no files or arguments.
`timescale 1ns / 1ps

module tb_overwriting_ring_buffer;
  import orb_pkg::*;

  localparam int DEPTH      = 8;
  localparam int SETTLE     = 12;
  localparam int STALL_MAX  = 5000;

  logic              clk;
  logic              rst      = 1'b1;
  logic              push     = 1'b0;
  logic              full;
  orb_in_t           in_data  = '0;
  logic              empty;
  logic              pop      = 1'b0;
  orb_out_t          out_data;
  logic              cfg_we   = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;

  // ring model
  logic [7:0]  ring [DEPTH];
  int unsigned wr_pos;
  int unsigned fill;
  int unsigned size_reg;
  orb_out_t    drained_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned stall_cycles;

  overwriting_ring_buffer #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned ring_span();
    int unsigned s;
    s = size_reg;
    if (s == 0) s = 1;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  task automatic ring_apply(orb_in_t w);
    int unsigned span;
    int unsigned pos;
    int unsigned k;
    orb_out_t    b;
    span = ring_span();
    if (wr_pos >= span) wr_pos = 0;
    if (fill > span) fill = span;
    if (w.command == CMD_PUSH) begin
      ring[wr_pos] = w.data_in;
      wr_pos = (wr_pos + 1 >= span) ? 0 : wr_pos + 1;
      if (fill < span) fill++;
    end else if (fill != 0) begin
      pos = wr_pos + span - fill;
      if (pos >= span) pos -= span;
      for (k = 0; k < fill; k++) begin
        b.data_out = ring[pos];
        b.last     = (k + 1 == fill);
        drained_q.push_back(b);
        pos = (pos + 1 >= span) ? 0 : pos + 1;
      end
      fill = 0;
    end
  endtask

  // returns 1 when the word did something (an empty drain does nothing)
  task automatic send_word(input orb_cmd_t cmd, input logic [7:0] b, output bit counted);
    orb_in_t w;
    w.command = cmd;
    w.data_in = b;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    counted = (cmd == CMD_PUSH) || (fill != 0);
    ring_apply(w);
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    while (drained_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_reg = v;
    wr_pos   = 0;
    fill     = 0;
  endtask

  task automatic push_bytes(int unsigned n);
    bit c;
    for (int unsigned i = 0; i < n; i++) send_word(CMD_PUSH, 8'($urandom_range(0, 255)), c);
  endtask

  task automatic test_reset_size();
    bit c;
    send_word(CMD_DRAIN, 8'h00, c);
    send_word(CMD_PUSH, 8'h00, c);
    send_word(CMD_PUSH, 8'hFF, c);
    send_word(CMD_DRAIN, 8'hFF, c);
    send_word(CMD_DRAIN, 8'h00, c);
  endtask

  task automatic test_size_limits();
    bit c;
    write_size(4'd1);
    send_word(CMD_PUSH, 8'h3C, c);
    send_word(CMD_PUSH, 8'hC3, c);
    send_word(CMD_DRAIN, 8'h00, c);
    write_size(4'd0);
    send_word(CMD_PUSH, 8'h81, c);
    send_word(CMD_DRAIN, 8'h7E, c);
    write_size(4'd15);
    for (int unsigned i = 0; i < 9; i++) send_word(CMD_PUSH, 8'(i * 8'h1D), c);
    send_word(CMD_DRAIN, 8'h00, c);
    write_size(4'd8);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned done;
    int unsigned roll;
    bit c;
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        if ($urandom_range(0, 9) < 7) write_size(SIZE_W'($urandom_range(1, DEPTH)));
        else write_size(SIZE_W'($urandom_range(0, 15)));
      end
      if (roll >= 90) begin
        // noise: random word with random command
        send_word(orb_cmd_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), c);
        done += c;
      end else begin
        roll = $urandom_range(0, 12);
        push_bytes(roll);
        send_word(CMD_DRAIN, 8'($urandom_range(0, 255)), c);
        done += roll + c;
      end
    end
  endtask

  task automatic test_hold_after_drain();
    bit c;
    for (int unsigned i = 0; i < 3; i++) begin
      push_bytes($urandom_range(1, 10));
      send_word(CMD_DRAIN, 8'h00, c);
      hold_until_drained();
      push_bytes($urandom_range(0, 3));
    end
  endtask

  always @(posedge clk) begin : result_check
    orb_out_t exp_word;
    if (!rst && pop && !empty) begin
      if (drained_q.size() == 0) begin
        $error("unexpected word: data_out=%h last=%b", out_data.data_out, out_data.last);
        mismatch_count++;
      end else begin
        exp_word = drained_q.pop_front();
        if (out_data.data_out !== exp_word.data_out) begin
          $error("data_out: expected %h, actual %h", exp_word.data_out, out_data.data_out);
          mismatch_count++;
        end
        if (out_data.last !== exp_word.last) begin
          $error("last: expected %b, actual %b", exp_word.last, out_data.last);
          mismatch_count++;
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    wr_pos         = 0;
    fill           = 0;
    size_reg       = 8;
    mismatch_count = 0;
    stall_cycles   = 0;
    send_idle_pct  = 6;
    recv_idle_pct  = 55;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_size();
    test_size_limits();
    test_random_traffic(130);

    send_idle_pct = 55;
    recv_idle_pct = 6;
    test_random_traffic(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_hold_after_drain();
    test_random_traffic(130);

    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/orb_pkg.sv
src/orb_ram.sv
src/orb_fifo.sv
src/orb_front.sv
src/orb_back.sv
src/overwriting_ring_buffer.sv
verif/tb_overwriting_ring_buffer.sv
